@@ sv/cfb_pkg.sv @@
// shared types, frame constants and crc function for the command frame builder
`timescale 1ns / 1ps
package cfb_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] SYNC_0 = 8'hFF;
  localparam logic [7:0] SYNC_1 = 8'h81;
  localparam logic [7:0] PROD_0 = 8'h53;  // 'S'
  localparam logic [7:0] PROD_1 = 8'h42;  // 'B'
  localparam logic [7:0] PROD_2 = 8'h31;  // '1'
  localparam logic [7:0] PROD_3 = 8'h43;  // 'C'

  localparam int HDR_LEN = 9;
  localparam logic [3:0] IDX_HDR_LAST  = 4'd8;
  localparam logic [3:0] IDX_START_END = 4'd10;
  localparam logic [3:0] IDX_DATA_END  = 4'd2;

  // one classified request passed from front to back
  typedef struct packed {
    logic       is_start;
    logic       last;      // start: empty payload; data: final payload byte
    logic [7:0] b0;        // command id or payload byte
    logic [7:0] b1;        // action id
    logic [7:0] b2;        // payload length
  } cmd_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input cmd_t c);
    logic [7:0] r;
    case (idx)
      4'd0:    r = SYNC_0;
      4'd1:    r = SYNC_1;
      4'd2:    r = PROD_0;
      4'd3:    r = PROD_1;
      4'd4:    r = PROD_2;
      4'd5:    r = PROD_3;
      4'd6:    r = c.b0;
      4'd7:    r = c.b1;
      default: r = c.b2;
    endcase
    return r;
  endfunction

endpackage

@@ sv/cfb_front.sv @@
// front end: accepts items, tracks the open frame and classifies requests
`timescale 1ns / 1ps
module cfb_front
  import cfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       operation,
  input  logic [7:0] cmd_id,
  input  logic [7:0] act_id,
  input  logic [7:0] payload_length,
  input  logic [7:0] data_byte,
  output logic       q_push,
  output cmd_t       q_data
);

  logic       open_r, open_nxt;
  logic [7:0] rem_r, rem_nxt;

  always_comb begin
    open_nxt = open_r;
    rem_nxt  = rem_r;
    q_push   = 1'b0;
    q_data   = '0;
    if (accept) begin
      if (operation == OP_START) begin
        q_push          = 1'b1;
        q_data.is_start = 1'b1;
        q_data.last     = (payload_length == 8'd0);
        q_data.b0       = cmd_id;
        q_data.b1       = act_id;
        q_data.b2       = payload_length;
        open_nxt        = (payload_length != 8'd0);
        rem_nxt         = payload_length;
      end else if (open_r) begin
        // stray payload bytes with no open frame are dropped here
        q_push          = 1'b1;
        q_data.is_start = 1'b0;
        q_data.last     = (rem_r == 8'd1);
        q_data.b0       = data_byte;
        rem_nxt         = rem_r - 8'd1;
        open_nxt        = (rem_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      rem_r  <= 8'd0;
    end else begin
      open_r <= open_nxt;
      rem_r  <= rem_nxt;
    end
  end

endmodule

@@ sv/cfb_cmd_fifo.sv @@
// request queue between front and back end
`timescale 1ns / 1ps
module cfb_cmd_fifo
  import cfb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wdata,
  input  logic pop,
  output cmd_t rdata,
  output logic full,
  output logic not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rdata     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/cfb_back.sv @@
// back end: serializes each request into frame bytes, updates the crc
`timescale 1ns / 1ps
module cfb_back
  import cfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_frame_end
);

  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r;
  logic        end_r;

  logic        emit;
  logic [3:0]  idx_end;
  logic [7:0]  sel_byte;
  logic        sel_end;
  logic        sel_hash;
  logic [15:0] crc_base;

  assign emit = q_valid && (!vld_r || out_pop);

  always_comb begin
    if (q_head.is_start) begin
      idx_end = q_head.last ? IDX_START_END : IDX_HDR_LAST;
    end else begin
      idx_end = q_head.last ? IDX_DATA_END : 4'd0;
    end

    sel_end  = 1'b0;
    sel_hash = 1'b1;
    if (q_head.is_start && idx_r < 4'(HDR_LEN)) begin
      sel_byte = hdr_byte(idx_r, q_head);
    end else if (!q_head.is_start && idx_r == 4'd0) begin
      sel_byte = q_head.b0;
    end else if (idx_r == idx_end) begin
      sel_byte = crc_r[7:0];
      sel_end  = 1'b1;
      sel_hash = 1'b0;
    end else begin
      sel_byte = crc_r[15:8];
      sel_hash = 1'b0;
    end

    // a start request restarts the crc on its first sync byte
    crc_base = (q_head.is_start && idx_r == 4'd0) ? CRC_INIT : crc_r;
  end

  always_comb begin
    q_pop   = emit && (idx_r == idx_end);
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    vld_nxt = vld_r && !out_pop;
    if (emit) begin
      vld_nxt = 1'b1;
      idx_nxt = q_pop ? 4'd0 : idx_r + 4'd1;
      if (sel_hash) begin
        crc_nxt = crc_update(crc_base, sel_byte);
      end else if (sel_end) begin
        crc_nxt = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 4'd0;
      crc_r <= CRC_INIT;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= sel_byte;
      end_r  <= sel_end;
    end
  end

  assign out_empty     = !vld_r;
  assign out_byte      = byte_r;
  assign out_frame_end = end_r;

endmodule

@@ sv/command_frame_builder_crc16_top.sv @@
// top level of the command frame builder with crc-16
// usage:
//   input side is a queue: drive the item and in_push; it is taken when in_full is low.
//   in_operation 0 starts a frame from cmd, action and length; 1 carries one payload byte.
//   result side is a queue: while out_empty is low out_byte/out_frame_end hold the
//   oldest byte; out_pop takes it. out_frame_end marks the low crc byte of a frame.
//   payload bytes with no open frame are dropped; a start aborts an open frame.
// throughput:
//   a taken request is queued; its first byte is then registered in the back end output.
//   the back end emits one frame byte per cycle while the receiver keeps up: a start request
//   gives 9 bytes (11 with an empty payload), a payload request 1 byte (3 for the last one).
//   a request queue of CMD_DEPTH entries lets input be taken while the header
//   burst is still going out, so payload items stream at one per cycle while the receiver keeps up.
// reset (synchronous, rst_n low): queues empty, no frame open, crc at 0xFFFF.
// a stalled receiver holds the output byte; the back end stops, the request queue
// fills and in_full rises; nothing is lost.
`timescale 1ns / 1ps
module command_frame_builder_crc16_top
  import cfb_pkg::*;
#(
  parameter int CMD_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_operation,
  input  logic [7:0] in_cmd_id,
  input  logic [7:0] in_act_id,
  input  logic [7:0] in_payload_length,
  input  logic [7:0] in_data_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_frame_end
);

  logic accept;
  logic q_push, q_pop, q_valid;
  cmd_t q_wdata, q_head;

  assign accept = in_push && !in_full;

  cfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .operation      (in_operation),
    .cmd_id         (in_cmd_id),
    .act_id         (in_act_id),
    .payload_length (in_payload_length),
    .data_byte      (in_data_byte),
    .q_push         (q_push),
    .q_data         (q_wdata)
  );

  cfb_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_head),
    .full      (in_full),
    .not_empty (q_valid)
  );

  cfb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

endmodule

@@ sv/cfb_checker.sv @@
// port-level checks for the command frame builder and their bind
`timescale 1ns / 1ps
module cfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_frame_end
);

  // a waiting byte holds until it is popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_byte) && $stable(out_frame_end)))
    else $error("output byte changed while waiting");

  // reset leaves both queues empty
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // the input queue only fills on a taken request
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("in_full rose with no request taken");

endmodule

bind command_frame_builder_crc16_top cfb_checker u_cfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_push       (in_push),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_byte      (out_byte),
  .out_frame_end (out_frame_end)
);

@@ dv/tb.sv @@
// testbench for the command frame builder: predicts the frame and crc byte stream and checks it
`timescale 1ns / 1ps
module tb
  import cfb_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int TARGET_ITEMS   = 350;
  localparam int CALM_ITEMS     = 60;

  // running model of the frame stream and the bytes still owed by the block
  class frame_scoreboard;
    logic [15:0] crc;
    logic [7:0]  remaining;
    bit          open_frame;
    logic [8:0]  predicted_bytes[$];  // {frame_end, byte}
    int          errors;

    function new();
      crc        = 16'hFFFF;
      remaining  = 8'd0;
      open_frame = 1'b0;
      errors     = 0;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        if (c[0]) begin
          c = (c >> 1) ^ 16'hA001;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    function void emit(logic [7:0] b);
      predicted_bytes.push_back({1'b0, b});
      crc = crc_step(crc, b);
    endfunction

    // crc goes out high byte first and is not hashed itself
    function void close_frame();
      predicted_bytes.push_back({1'b0, crc[15:8]});
      predicted_bytes.push_back({1'b1, crc[7:0]});
      crc        = 16'hFFFF;
      open_frame = 1'b0;
      remaining  = 8'd0;
    endfunction

    function void note_request(logic op, logic [7:0] cmd, logic [7:0] act,
                               logic [7:0] len, logic [7:0] data);
      if (op == OP_START) begin
        // a start drops any open frame and restarts the crc
        crc = 16'hFFFF;
        emit(8'hFF);
        emit(8'h81);
        emit(8'h53);  // S
        emit(8'h42);  // B
        emit(8'h31);  // 1
        emit(8'h43);  // C
        emit(cmd);
        emit(act);
        emit(len);
        if (len == 8'd0) begin
          close_frame();
        end else begin
          open_frame = 1'b1;
          remaining  = len;
        end
      end else if (open_frame) begin
        emit(data);
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) begin
          close_frame();
        end
      end
      // payload byte with no open frame: dropped
    endfunction

    function void check_byte(logic [7:0] b, logic fe);
      logic [8:0] want;
      if (predicted_bytes.size() == 0) begin
        $error("out_byte: no byte expected, actual %02h", b);
        errors++;
        return;
      end
      want = predicted_bytes.pop_front();
      if (b !== want[7:0]) begin
        $error("out_byte: expected %02h, actual %02h", want[7:0], b);
        errors++;
      end
      if (fe !== want[8]) begin
        $error("out_frame_end: expected %0b, actual %0b", want[8], fe);
        errors++;
      end
    endfunction

    function int pending();
      return predicted_bytes.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic       in_full;
  logic       in_operation;
  logic [7:0] in_cmd_id;
  logic [7:0] in_act_id;
  logic [7:0] in_payload_length;
  logic [7:0] in_data_byte;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_byte;
  logic       out_frame_end;

  frame_scoreboard sb;
  bit tx_idle_en;
  bit rx_idle_en;
  bit long_hold_req;
  int stall_cycles = 0;
  int items_sent   = 0;

  command_frame_builder_crc16_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_operation     (in_operation),
    .in_cmd_id        (in_cmd_id),
    .in_act_id        (in_act_id),
    .in_payload_length(in_payload_length),
    .in_data_byte     (in_data_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_byte         (out_byte),
    .out_frame_end    (out_frame_end)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one request and hold it until the block takes it
  task automatic send_item(input logic op, input logic [7:0] cmd, input logic [7:0] act,
                           input logic [7:0] len, input logic [7:0] data);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_push           <= 1'b1;
    in_operation      <= op;
    in_cmd_id         <= cmd;
    in_act_id         <= act;
    in_payload_length <= len;
    in_data_byte      <= data;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // header with len, then n_data payload bytes (fewer than len leaves the frame open)
  task automatic send_frame(input int len, input int n_data);
    send_item(OP_START, rand8(), rand8(), 8'(len), rand8());
    for (int i = 0; i < n_data; i++) begin
      send_item(OP_DATA, rand8(), rand8(), rand8(), rand8());
    end
  endtask

  // receiver: random pop gaps, plus one long hold on request
  initial begin
    bit held;
    held    = 1'b0;
    out_pop = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req && !held) begin
        out_pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // sample both handshakes, feed the scoreboard, and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full) begin
        sb.note_request(in_operation, in_cmd_id, in_act_id, in_payload_length, in_data_byte);
      end
      if (out_pop && !out_empty) begin
        sb.check_byte(out_byte, out_frame_end);
      end
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int n_data;
    int pick;
    sb                = new();
    rst_n             = 1'b0;
    in_push           = 1'b0;
    in_operation      = OP_START;
    in_cmd_id         = 8'h00;
    in_act_id         = 8'h00;
    in_payload_length = 8'h00;
    in_data_byte      = 8'h00;
    tx_idle_en        = 1'b1;
    rx_idle_en        = 1'b1;
    long_hold_req     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: stray byte, empty payloads at field extremes, short frames, abort
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_item(OP_START, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_item(OP_START, 8'hFF, 8'hFF, 8'h00, 8'h00);
    send_item(OP_START, 8'h5A, 8'hA5, 8'h01, 8'hFF);
    send_item(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_item(OP_START, 8'h01, 8'h80, 8'h03, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_item(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_item(OP_DATA, 8'h55, 8'hAA, 8'h01, 8'h80);
    send_item(OP_DATA, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_item(OP_START, 8'h7F, 8'hFE, 8'h04, 8'h00);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h11);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h22);
    send_item(OP_START, 8'hC3, 8'h3C, 8'h02, 8'hFF);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h01);
    send_item(OP_DATA, 8'h00, 8'h00, 8'h00, 8'h7F);

    // longest frame while the receiver holds off, so the input side backs up
    tx_idle_en    = 1'b0;
    rx_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    send_frame(255, 255);

    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= TARGET_ITEMS - CALM_ITEMS) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(13, 40);
        end else begin
          len = $urandom_range(0, 12);
        end
        n_data = len;
        // cut the frame short now and then; the next start aborts it
        if (len > 0 && $urandom_range(0, 7) == 0) begin
          n_data = $urandom_range(0, len - 1);
        end
        send_frame(len, n_data);
      end else if (pick < 18) begin
        send_item(OP_DATA, rand8(), rand8(), rand8(), rand8());
      end else begin
        len = $urandom_range(0, 255);
        send_item(OP_START, rand8(), rand8(), 8'(len), rand8());
      end
    end
    in_push <= 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ command_frame_builder_crc16_top.f @@
sv/cfb_pkg.sv
sv/cfb_front.sv
sv/cfb_cmd_fifo.sv
sv/cfb_back.sv
sv/command_frame_builder_crc16_top.sv
sv/cfb_checker.sv
dv/tb.sv
